### design/utf8_sentence_clause_splitter_defines.svh
// Assertion macros used by the splitter's port-level checker.
// Depends on nothing; include by bare file name.
`ifndef UTF8_SENTENCE_CLAUSE_SPLITTER_DEFINES_SVH
`define UTF8_SENTENCE_CLAUSE_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USCS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
		else $error("splitter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define USCS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
		else $error("splitter check failed");

`endif

### design/uscs_pkg.sv
// Shared types and constants of the UTF-8 sentence / clause splitter.
// Used by the decoder, the chunk tracker and the top level; depends on nothing.
package uscs_pkg;

	localparam int unsigned MAX_TEXT_BYTES = 65536;
	localparam int POS_W   = $clog2(MAX_TEXT_BYTES + 1);
	localparam int OFF_W   = $clog2(MAX_TEXT_BYTES);
	localparam int BEGIN_W = 16;
	localparam int END_W   = 17;
	localparam int CP_W    = 21;

	// split modes
	localparam logic MODE_SENTENCE = 1'b0;
	localparam logic MODE_CLAUSE   = 1'b1;

	// code points of interest
	localparam logic [CP_W-1:0] CP_TAB        = 21'h00009;
	localparam logic [CP_W-1:0] CP_LF         = 21'h0000A;
	localparam logic [CP_W-1:0] CP_FF         = 21'h0000C;
	localparam logic [CP_W-1:0] CP_CR         = 21'h0000D;
	localparam logic [CP_W-1:0] CP_SPACE      = 21'h00020;
	localparam logic [CP_W-1:0] CP_NBSP       = 21'h000A0;
	localparam logic [CP_W-1:0] CP_OGHAM_SP   = 21'h01680;
	localparam logic [CP_W-1:0] CP_EN_QUAD    = 21'h02000;
	localparam logic [CP_W-1:0] CP_HAIR_SP    = 21'h0200A;
	localparam logic [CP_W-1:0] CP_NNBSP      = 21'h0202F;
	localparam logic [CP_W-1:0] CP_MMSP       = 21'h0205F;
	localparam logic [CP_W-1:0] CP_IDEO_SP    = 21'h03000;
	localparam logic [CP_W-1:0] CP_EXCL       = 21'h00021;
	localparam logic [CP_W-1:0] CP_STOP       = 21'h0002E;
	localparam logic [CP_W-1:0] CP_QUEST      = 21'h0003F;
	localparam logic [CP_W-1:0] CP_IDEO_STOP  = 21'h03002;
	localparam logic [CP_W-1:0] CP_FW_EXCL    = 21'h0FF01;
	localparam logic [CP_W-1:0] CP_FW_QUEST   = 21'h0FF1F;
	localparam logic [CP_W-1:0] CP_COMMA      = 21'h0002C;
	localparam logic [CP_W-1:0] CP_SEMI       = 21'h0003B;
	localparam logic [CP_W-1:0] CP_FW_COMMA   = 21'h0FF0C;
	localparam logic [CP_W-1:0] CP_FW_SEMI    = 21'h0FF1B;

	// advance / end-of-text control shared by the state-holding units
	typedef struct packed {
		logic step;
		logic last;
	} step_ctl_t;

	// decoder result for one byte
	typedef struct packed {
		logic            cp_valid;
		logic [CP_W-1:0] cp;
		logic [OFF_W-1:0] cp_begin;
		logic [POS_W-1:0] end_pos;
		logic            overflow;
	} dec_out_t;

	// chunk tracker result for one byte
	typedef struct packed {
		logic            have;
		logic [OFF_W-1:0] cb;
		logic [POS_W-1:0] ce;
	} chunk_out_t;

endpackage

### design/utf8_sentence_clause_splitter.sv
// Top level of the UTF-8 sentence / clause splitter: input and result registers,
// split mode register. Depends on uscs_pkg, uscs_decoder and uscs_chunker.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-------------------------------
//  text    | text_valid, text_stall, data_byte,        | text_valid && !text_stall
//          | last_byte                                 |
//  result  | result_valid, result_stall, chunk_valid,  | result_valid && !result_stall
//          | chunk_begin, chunk_end, text_done,        |
//          | length_overflow                           |
//  config  | cfg_valid, cfg_ready, split_mode          | cfg_valid && cfg_ready
//
// One byte per cycle sustained while result_stall does not hold the result register.
// A byte is decoded and classified while it sits in the input register; its result
// (if any) loads into the result register at the next advancing edge and is offered
// from there. Reset returns all text state and the split mode to their initial values.
// A stall on the result side holds the result register; the input register drains
// even bytes that give no result only once the result register frees, so a result
// stall reaches text_stall in the same cycle.
module utf8_sentence_clause_splitter (
	input  logic        clk,
	input  logic        arst_n,
	// text channel
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        chunk_valid,
	output logic [15:0] chunk_begin,
	output logic [16:0] chunk_end,
	output logic        text_done,
	output logic        length_overflow,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        split_mode
);
	import uscs_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic               valid_s2;
	logic               chunk_valid_s2;
	logic [BEGIN_W-1:0] begin_s2;
	logic [END_W-1:0]   end_s2;
	logic               done_s2;
	logic               ovf_s2;

	logic       mode_q;
	logic       advance;
	logic       emit;
	step_ctl_t  ctl;
	dec_out_t   dec;
	chunk_out_t res;

	// advance the held byte when the result register is free or being taken
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign text_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	assign ctl.step = advance;
	assign ctl.last = last_s1;

	uscs_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (byte_s1),
		.dec       (dec)
	);

	uscs_chunker u_chunker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.split_mode (mode_q),
		.dec        (dec),
		.res        (res)
	);

	// a final byte always gives a result, other bytes only when a chunk closes
	assign emit = res.have || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SENTENCE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= split_mode;
		end
	end

	// hold the byte while stalled, load a new one on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// drop the range to zero when no chunk is carried
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			chunk_valid_s2 <= res.have;
			begin_s2       <= res.have ? BEGIN_W'(res.cb) : '0;
			end_s2         <= res.have ? END_W'(res.ce) : '0;
			done_s2        <= last_s1;
			ovf_s2         <= dec.overflow;
		end
	end

	assign result_valid    = valid_s2;
	assign chunk_valid     = chunk_valid_s2;
	assign chunk_begin     = begin_s2;
	assign chunk_end       = end_s2;
	assign text_done       = done_s2;
	assign length_overflow = ovf_s2;

endmodule

### design/uscs_decoder.sv
// Strict UTF-8 decoder with byte position and overflow tracking.
// Depends on uscs_pkg.
module uscs_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  uscs_pkg::step_ctl_t ctl,
	input  logic [7:0]         data_byte,
	output uscs_pkg::dec_out_t dec
);
	import uscs_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic [1:0]       rem_q;
	logic [2:0]       len_q;
	logic [CP_W-1:0]  part_q;
	logic [OFF_W-1:0] sbeg_q;

	logic [POS_W-1:0] pos_n;
	logic             ovf_n;
	logic [1:0]       rem_n;
	logic [2:0]       len_n;
	logic [CP_W-1:0]  part_n;
	logic [OFF_W-1:0] sbeg_n;
	logic             at_max;
	logic [OFF_W-1:0] offset;
	logic             cont_ok;
	logic             first_cont;

	always_comb begin
		at_max = (pos_q == POS_W'(MAX_TEXT_BYTES));
		offset = at_max ? OFF_W'(MAX_TEXT_BYTES - 1) : pos_q[OFF_W-1:0];
		pos_n  = at_max ? pos_q : pos_q + 1'b1;
		ovf_n  = ovf_q | at_max;

		rem_n  = rem_q;
		len_n  = len_q;
		part_n = part_q;
		sbeg_n = sbeg_q;

		dec.cp_valid = 1'b0;
		dec.cp       = {13'd0, data_byte};
		dec.cp_begin = offset;
		dec.end_pos  = pos_n;
		dec.overflow = ovf_n;

		// check continuation, with the tighter ranges on the second byte
		first_cont = ({1'b0, rem_q} + 3'd1 == len_q);
		cont_ok    = (data_byte[7:6] == 2'b10);
		if (cont_ok && first_cont) begin
			if (len_q == 3'd3 && part_q == 21'd0)
				cont_ok = (data_byte >= 8'hA0);
			else if (len_q == 3'd3 && part_q == 21'hD)
				cont_ok = (data_byte <= 8'h9F);
			else if (len_q == 3'd4 && part_q == 21'd0)
				cont_ok = (data_byte >= 8'h90);
			else if (len_q == 3'd4 && part_q == 21'd4)
				cont_ok = (data_byte <= 8'h8F);
		end

		if (rem_q != 2'd0 && cont_ok) begin
			part_n = {part_q[CP_W-7:0], data_byte[5:0]};
			rem_n  = rem_q - 2'd1;
			if (rem_n == 2'd0) begin
				dec.cp_valid = 1'b1;
				dec.cp       = part_n;
				dec.cp_begin = sbeg_q;
			end
		end else begin
			// drop any broken sequence and treat the byte as a lead
			rem_n = 2'd0;
			if (!data_byte[7]) begin
				dec.cp_valid = 1'b1;
			end else if (data_byte >= 8'hC2 && data_byte <= 8'hF4) begin
				sbeg_n = offset;
				if (data_byte < 8'hE0) begin
					len_n  = 3'd2;
					part_n = {16'd0, data_byte[4:0]};
				end else if (data_byte < 8'hF0) begin
					len_n  = 3'd3;
					part_n = {17'd0, data_byte[3:0]};
				end else begin
					len_n  = 3'd4;
					part_n = {18'd0, data_byte[2:0]};
				end
				rem_n = 2'(len_n - 3'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ovf_q  <= 1'b0;
			rem_q  <= 2'd0;
			len_q  <= 3'd0;
			part_q <= '0;
			sbeg_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				pos_q  <= '0;
				ovf_q  <= 1'b0;
				rem_q  <= 2'd0;
				len_q  <= 3'd0;
				part_q <= '0;
				sbeg_q <= '0;
			end else begin
				pos_q  <= pos_n;
				ovf_q  <= ovf_n;
				rem_q  <= rem_n;
				len_q  <= len_n;
				part_q <= part_n;
				sbeg_q <= sbeg_n;
			end
		end
	end

endmodule

### design/uscs_chunker.sv
// Chunk tracker: white-space trimming, split marks and end-of-text chunk.
// Depends on uscs_pkg.
module uscs_chunker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uscs_pkg::step_ctl_t  ctl,
	input  logic                 split_mode,
	input  uscs_pkg::dec_out_t   dec,
	output uscs_pkg::chunk_out_t res
);
	import uscs_pkg::*;

	function automatic logic is_white(input logic [CP_W-1:0] cp);
		return cp == CP_SPACE || cp == CP_NBSP || cp == CP_OGHAM_SP ||
		       (cp >= CP_EN_QUAD && cp <= CP_HAIR_SP) || cp == CP_NNBSP ||
		       cp == CP_MMSP || cp == CP_IDEO_SP ||
		       cp == CP_TAB || cp == CP_LF || cp == CP_CR || cp == CP_FF;
	endfunction

	function automatic logic is_ender(input logic [CP_W-1:0] cp);
		return cp == CP_EXCL || cp == CP_STOP || cp == CP_QUEST ||
		       cp == CP_IDEO_STOP || cp == CP_FW_EXCL || cp == CP_FW_QUEST;
	endfunction

	function automatic logic is_clause(input logic [CP_W-1:0] cp);
		return cp == CP_COMMA || cp == CP_SEMI || cp == CP_FW_COMMA || cp == CP_FW_SEMI;
	endfunction

	logic             open_q, trim_q, any_q;
	logic [OFF_W-1:0] obeg_q;
	logic             open_n, trim_n, any_n;
	logic [OFF_W-1:0] obeg_n;
	logic             ender, splits;

	always_comb begin
		open_n = open_q;
		trim_n = trim_q;
		any_n  = any_q;
		obeg_n = obeg_q;
		res.have = 1'b0;
		res.cb   = obeg_q;
		res.ce   = dec.end_pos;

		ender  = is_ender(dec.cp);
		splits = ender || (split_mode == MODE_CLAUSE && is_clause(dec.cp));

		if (dec.cp_valid && !(!open_q && trim_q && is_white(dec.cp))) begin
			if (splits) begin
				if (open_q) begin
					res.have = 1'b1;
					open_n   = 1'b0;
					any_n    = 1'b1;
					trim_n   = (split_mode == MODE_CLAUSE) ? ender : 1'b1;
				end
			end else if (!open_q) begin
				open_n = 1'b1;
				obeg_n = dec.cp_begin;
				trim_n = 1'b0;
			end
		end

		// close the trailing chunk, or report the whole text
		if (ctl.last && !res.have) begin
			if (open_n) begin
				res.have = 1'b1;
				res.cb   = obeg_n;
			end else if (!any_n) begin
				res.have = 1'b1;
				res.cb   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			trim_q <= 1'b1;
			any_q  <= 1'b0;
			obeg_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				open_q <= 1'b0;
				trim_q <= 1'b1;
				any_q  <= 1'b0;
				obeg_q <= '0;
			end else begin
				open_q <= open_n;
				trim_q <= trim_n;
				any_q  <= any_n;
				obeg_q <= obeg_n;
			end
		end
	end

endmodule

### design/uscs_checker.sv
// Port-level checker for the splitter, bound to the top level.
// Depends on utf8_sentence_clause_splitter_defines.svh.
`include "utf8_sentence_clause_splitter_defines.svh"

module uscs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        chunk_valid,
	input logic [15:0] chunk_begin,
	input logic [16:0] chunk_end,
	input logic        text_done
);

	// hold a stalled result
	`USCS_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)

	// a reported chunk is never empty
	`USCS_ASSERT_IMPLY(a_range_order, clk, arst_n, result_valid && chunk_valid, chunk_end > {1'b0, chunk_begin})

	// a result without a chunk only closes a text, with a zero range
	`USCS_ASSERT_IMPLY(a_empty_result, clk, arst_n, result_valid && !chunk_valid, text_done && chunk_begin == 16'd0 && chunk_end == 17'd0)

	// mid-text results always carry a chunk
	`USCS_ASSERT_IMPLY(a_mid_text_chunk, clk, arst_n, result_valid && !text_done, chunk_valid)

endmodule

bind utf8_sentence_clause_splitter uscs_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.chunk_valid  (chunk_valid),
	.chunk_begin  (chunk_begin),
	.chunk_end    (chunk_end),
	.text_done    (text_done)
);

### test/utf8_sentence_clause_splitter_checker.sv
`timescale 1ns / 100ps
// Result checker for the UTF-8 sentence / clause splitter: watches the text,
// result and configuration channels, predicts chunk ranges and compares them.
// Depends on uscs_pkg for the code point constants and the text size limit.
module utf8_sentence_clause_splitter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	input  logic        text_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        chunk_valid,
	input  logic [15:0] chunk_begin,
	input  logic [16:0] chunk_end,
	input  logic        text_done,
	input  logic        length_overflow,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        split_mode,
	output int          fail_count,
	output int          pending
);
	import uscs_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [15:0] cbeg;
		logic [16:0] cend;
		logic        done;
		logic        ovf;
	} chunk_rec_t;

	chunk_rec_t  chunk_q[$];

	logic        clause_mode;
	logic [16:0] text_pos;
	logic [1:0]  cont_left;
	logic [2:0]  seq_len;
	logic [20:0] cp_acc;
	logic [15:0] seq_start;
	logic        chunk_open;
	logic [15:0] open_at;
	logic        skip_space;
	logic        any_chunk;
	logic        over_len;

	function automatic logic is_blank(input logic [20:0] cp);
		return cp == CP_SPACE || cp == CP_NBSP || cp == CP_OGHAM_SP ||
			(cp >= CP_EN_QUAD && cp <= CP_HAIR_SP) || cp == CP_NNBSP ||
			cp == CP_MMSP || cp == CP_IDEO_SP || cp == CP_TAB || cp == CP_LF ||
			cp == CP_CR || cp == CP_FF;
	endfunction

	function automatic logic ends_sentence(input logic [20:0] cp);
		return cp == CP_EXCL || cp == CP_STOP || cp == CP_QUEST ||
			cp == CP_IDEO_STOP || cp == CP_FW_EXCL || cp == CP_FW_QUEST;
	endfunction

	function automatic logic marks_clause(input logic [20:0] cp);
		return cp == CP_COMMA || cp == CP_SEMI || cp == CP_FW_COMMA || cp == CP_FW_SEMI;
	endfunction

	task automatic clear_text_state();
		text_pos    = '0;
		cont_left   = '0;
		seq_len     = '0;
		cp_acc      = '0;
		seq_start   = '0;
		chunk_open  = 1'b0;
		open_at     = '0;
		skip_space  = 1'b1;
		any_chunk   = 1'b0;
		over_len    = 1'b0;
	endtask

	// feed one decoded code point to the chunk tracker
	task automatic track_codepoint(input logic [20:0] cp, input logic [15:0] start,
			input logic [16:0] stop, output logic hit, output logic [15:0] cb,
			output logic [16:0] ce);
		logic splits;
		hit = 1'b0;
		cb  = '0;
		ce  = '0;
		if (chunk_open || !skip_space || !is_blank(cp)) begin
			splits = ends_sentence(cp) || (clause_mode == MODE_CLAUSE && marks_clause(cp));
			if (splits) begin
				if (chunk_open) begin
					hit        = 1'b1;
					cb         = open_at;
					ce         = stop;
					chunk_open = 1'b0;
					any_chunk  = 1'b1;
					skip_space = (clause_mode == MODE_CLAUSE) ? ends_sentence(cp) : 1'b1;
				end
			end else if (!chunk_open) begin
				chunk_open  = 1'b1;
				open_at     = start;
				skip_space  = 1'b0;
			end
		end
	endtask

	task automatic predict_chunk(input logic [7:0] b, input logic fin);
		logic [15:0] offs;
		logic [16:0] stop;
		logic [15:0] cb;
		logic [16:0] ce;
		logic        have;
		logic        as_lead;
		logic        ok;
		chunk_rec_t  rec;
		have    = 1'b0;
		as_lead = 1'b1;
		cb      = '0;
		ce      = '0;
		// saturate offsets once the text runs past the limit
		if (text_pos >= MAX_TEXT_BYTES) begin
			over_len = 1'b1;
			offs     = 16'(MAX_TEXT_BYTES - 1);
			text_pos = 17'(MAX_TEXT_BYTES);
		end else begin
			offs     = text_pos[15:0];
			text_pos = text_pos + 17'd1;
		end
		stop = text_pos;

		if (cont_left != 0) begin
			ok = (b[7:6] == 2'b10);
			if (ok && {1'b0, cont_left} + 3'd1 == seq_len) begin
				// reject overlong forms, surrogates and code points past U+10FFFF
				if (seq_len == 3'd3 && cp_acc == 21'h0)
					ok = b >= 8'hA0;
				else if (seq_len == 3'd3 && cp_acc == 21'hD)
					ok = b <= 8'h9F;
				else if (seq_len == 3'd4 && cp_acc == 21'h0)
					ok = b >= 8'h90;
				else if (seq_len == 3'd4 && cp_acc == 21'h4)
					ok = b <= 8'h8F;
			end
			if (ok) begin
				as_lead   = 1'b0;
				cp_acc    = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0)
					track_codepoint(cp_acc, seq_start, stop, have, cb, ce);
			end else begin
				// drop the lead, then look at this byte again as a new lead
				cont_left = '0;
			end
		end

		if (as_lead) begin
			if (b < 8'h80) begin
				track_codepoint({13'h0, b}, offs, stop, have, cb, ce);
			end else if (b >= 8'hC2 && b <= 8'hF4) begin
				seq_start = offs;
				if (b < 8'hE0) begin
					seq_len = 3'd2;
					cp_acc  = {16'h0, b[4:0]};
				end else if (b < 8'hF0) begin
					seq_len = 3'd3;
					cp_acc  = {17'h0, b[3:0]};
				end else begin
					seq_len = 3'd4;
					cp_acc  = {18'h0, b[2:0]};
				end
				cont_left = 2'(seq_len - 3'd1);
			end
		end

		if (fin && !have) begin
			if (chunk_open) begin
				cb   = open_at;
				ce   = stop;
				have = 1'b1;
			end else if (!any_chunk) begin
				cb   = '0;
				ce   = stop;
				have = 1'b1;
			end
		end

		if (have || fin) begin
			rec.valid = have;
			rec.cbeg  = have ? cb : 16'h0;
			rec.cend  = have ? ce : 17'h0;
			rec.done  = fin;
			rec.ovf   = over_len;
			chunk_q.insert(chunk_q.size(), rec);
		end
		if (fin)
			clear_text_state();
	endtask

	always @(posedge clk or negedge arst_n) begin
		chunk_rec_t got;
		chunk_rec_t want;
		if (!arst_n) begin
			clause_mode = MODE_SENTENCE;
			clear_text_state();
			chunk_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got.valid = chunk_valid;
				got.cbeg  = chunk_begin;
				got.cend  = chunk_end;
				got.done  = text_done;
				got.ovf   = length_overflow;
				if (chunk_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result valid=%0b begin=%0d end=%0d done=%0b ovf=%0b",
							$time, got.valid, got.cbeg, got.cend, got.done, got.ovf);
				end else begin
					want = chunk_q.pop_front();
					if (got.valid !== want.valid || got.cbeg !== want.cbeg ||
							got.cend !== want.cend || got.done !== want.done ||
							got.ovf !== want.ovf) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("%0t: result mismatch, expected valid=%0b begin=%0d end=%0d",
								$time, want.valid, want.cbeg, want.cend);
							$write(" done=%0b ovf=%0b,", want.done, want.ovf);
							$display(" got valid=%0b begin=%0d end=%0d done=%0b ovf=%0b",
								got.valid, got.cbeg, got.cend, got.done, got.ovf);
						end
					end
				end
			end
			if (text_valid && !text_stall)
				predict_chunk(data_byte, last_byte);
			if (cfg_valid && cfg_ready)
				clause_mode = split_mode;
			pending = chunk_q.size();
		end
	end

endmodule

### test/utf8_sentence_clause_splitter_test.sv
`timescale 1ns / 100ps
// Top of the splitter testbench: clock, reset, text and mode stimulus, verdict.
// Depends on uscs_pkg, the splitter RTL and utf8_sentence_clause_splitter_checker.
module utf8_sentence_clause_splitter_test;
	import uscs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        chunk_valid;
	logic [15:0] chunk_begin;
	logic [16:0] chunk_end;
	logic        text_done;
	logic        length_overflow;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        split_mode = MODE_SENTENCE;

	int          fail_count;
	int          pending;

	// idle rates in percent, changed per phase
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;

	// bytes of the text being assembled before it is sent
	logic [7:0]  text_buf[$];

	always #5 clk = ~clk;

	utf8_sentence_clause_splitter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_stall      (text_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.chunk_valid     (chunk_valid),
		.chunk_begin     (chunk_begin),
		.chunk_end       (chunk_end),
		.text_done       (text_done),
		.length_overflow (length_overflow),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.split_mode      (split_mode)
	);

	utf8_sentence_clause_splitter_checker u_chunk_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_stall      (text_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.chunk_valid     (chunk_valid),
		.chunk_begin     (chunk_begin),
		.chunk_end       (chunk_end),
		.text_done       (text_done),
		.length_overflow (length_overflow),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.split_mode      (split_mode),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	// Receiver back-pressure: a fresh coin toss every cycle, driven on the falling
	// edge so the splitter sees a settled stall at the next rising edge.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	// Offer one byte and hold it until the transfer. Entered and left on a falling
	// edge, so text_valid gets exactly one assignment per step and stays high
	// across back-to-back bytes.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_gap_pct) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= fin;
		do @(posedge clk); while (text_stall);
		@(negedge clk);
	endtask

	// Stop sending, wait for every expected chunk, then give the pipeline time to
	// flush bytes that produce no result before touching the mode register.
	task automatic settle();
		text_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// One mode write; only ever called after settle(), so the splitter is idle.
	task automatic write_mode(input logic m);
		cfg_valid  <= 1'b1;
		split_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_cont();
		add_byte(8'($urandom_range(8'h80, 8'hBF)));
	endtask

	// Append one random token: mostly well-formed characters, with white space,
	// both kinds of punctuation, and a tail of broken sequences and noise.
	task automatic add_token();
		logic [7:0] lead;
		logic [7:0] brk;
		case ($urandom_range(19))
			0, 1, 2, 3: add_byte(8'($urandom_range(8'h61, 8'h7A)));
			4: add_byte(8'($urandom_range(8'h41, 8'h5A)));
			5: add_byte(8'($urandom_range(0, 127)));
			6, 7: case ($urandom_range(10))
				0: add_byte(8'h20);
				1: add_byte(8'h09);
				2: add_byte(8'h0A);
				3: add_byte(8'h0D);
				4: add_byte(8'h0C);
				5: add_str("\302\240");
				6: add_str("\341\232\200");
				7: begin
					// the U+2000..U+200A run of spaces
					add_str("\342\200");
					add_byte(8'($urandom_range(8'h80, 8'h8A)));
				end
				8: add_str("\342\200\257");
				9: add_str("\342\201\237");
				default: add_str("\343\200\200");
			endcase
			8, 9, 10: case ($urandom_range(5))
				0: add_str("!");
				1: add_str(".");
				2: add_str("?");
				3: add_str("\343\200\202");
				4: add_str("\357\274\201");
				default: add_str("\357\274\237");
			endcase
			11, 12: case ($urandom_range(3))
				0: add_str(",");
				1: add_str(";");
				2: add_str("\357\274\214");
				default: add_str("\357\274\233");
			endcase
			13, 14: begin
				add_byte(8'($urandom_range(8'hC2, 8'hDF)));
				add_cont();
			end
			15: begin
				lead = 8'($urandom_range(8'hE0, 8'hEF));
				add_byte(lead);
				if (lead == 8'hE0)
					add_byte(8'($urandom_range(8'hA0, 8'hBF)));
				else if (lead == 8'hED)
					add_byte(8'($urandom_range(8'h80, 8'h9F)));
				else
					add_cont();
				add_cont();
			end
			16: begin
				lead = 8'($urandom_range(8'hF0, 8'hF4));
				add_byte(lead);
				if (lead == 8'hF0)
					add_byte(8'($urandom_range(8'h90, 8'hBF)));
				else if (lead == 8'hF4)
					add_byte(8'($urandom_range(8'h80, 8'h8F)));
				else
					add_cont();
				add_cont();
				add_cont();
			end
			17: case ($urandom_range(2))
				0: begin
					// truncated: the breaking byte is never a continuation
					lead = 8'($urandom_range(8'hC2, 8'hF4));
					add_byte(lead);
					if (lead >= 8'hE0 && $urandom_range(1))
						add_cont();
					brk = 8'($urandom_range(0, 255));
					if (brk[7:6] == 2'b10)
						brk[6] = 1'b1;
					add_byte(brk);
				end
				1: case ($urandom_range(3))
					// second byte just outside the strict range of its lead
					0: begin
						add_byte(8'hE0);
						add_byte(8'($urandom_range(8'h80, 8'h9F)));
					end
					1: begin
						add_byte(8'hED);
						add_byte(8'($urandom_range(8'hA0, 8'hBF)));
					end
					2: begin
						add_byte(8'hF0);
						add_byte(8'($urandom_range(8'h80, 8'h8F)));
					end
					default: begin
						add_byte(8'hF4);
						add_byte(8'($urandom_range(8'h90, 8'hBF)));
					end
				endcase
				default: add_byte(8'($urandom_range(8'hC2, 8'hF4)));
			endcase
			18: add_byte(8'($urandom_range(0, 255)));
			default: begin
				// stray continuations, C0, C1 and F5..FF
				if ($urandom_range(1))
					add_byte(8'($urandom_range(8'h80, 8'hC1)));
				else
					add_byte(8'($urandom_range(8'hF5, 8'hFF)));
			end
		endcase
	endtask

	// Send the assembled text, marking its final byte. Now and then flip the mode
	// partway through, which is legal as long as the splitter has gone quiet.
	task automatic send_text(input logic allow_flip);
		int n;
		int flip_at;
		n = text_buf.size();
		flip_at = (allow_flip && $urandom_range(7) == 0) ? $urandom_range(n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == flip_at && i != 0) begin
				settle();
				write_mode(~split_mode);
			end
			send_byte(text_buf[i], i == n - 1);
		end
		text_buf.delete();
	endtask

	task automatic random_phase(input int target);
		int sent;
		int tokens;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(3) == 0) begin
				settle();
				write_mode(~split_mode);
			end
			tokens = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			repeat (tokens) add_token();
			sent += text_buf.size();
			send_text(1'b1);
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase one: sender idles about a third of the time, receiver half.
		send_gap_pct   = 32;
		recv_stall_pct = 50;

		// Sentence mode. Leading space and tab skipped, a chunk closed by '!',
		// an ideographic full stop with no open chunk, a full-width question mark,
		// then an invalid byte, a stray continuation, C0, a truncated two-byte lead
		// whose breaker opens a chunk, an overlong three-byte start, and a lead
		// byte pending on the final byte.
		add_str(" \tHi! \343\200\202Y\357\274\237\377\200\300\302z\340\200");
		add_byte(8'hF4);
		send_text(1'b0);
		// one-byte text of NUL: the whole text comes back
		add_byte(8'h00);
		send_text(1'b0);

		// Clause mode: the space after a semicolon is kept, and a comma on the final
		// byte closes the chunk.
		settle();
		write_mode(MODE_CLAUSE);
		add_str("a; b,");
		send_text(1'b0);
		// trailing white space after a closed chunk: an empty final result
		add_str("x. ");
		send_text(1'b0);

		random_phase(185);

		// Phase two: the rates swap over. Drain fully first, so at least once the
		// sender holds off until every expected chunk has arrived.
		settle();
		send_gap_pct   = 50;
		recv_stall_pct = 32;
		write_mode(MODE_SENTENCE);
		random_phase(185);

		// Phase three: full rate on both sides.
		settle();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		write_mode(MODE_CLAUSE);
		random_phase(185);

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
